[rtl/oal_pkg.sv]
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and constants of the ordered array list: request codes,
// status codes and the command that is broadcast along the row of cells.
// ----------------------------------------------------------------------------
package oal_pkg;

	// width of a list index, wide enough for the largest supported capacity
	localparam int IDX_W = 7;
	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int POS_W = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INS_HEAD = 3'd0,
		FUNC_INS_TAIL = 3'd1,
		FUNC_INS_POS  = 3'd2,
		FUNC_REM_HEAD = 3'd3,
		FUNC_REM_TAIL = 3'd4,
		FUNC_REM_POS  = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// command seen by every cell in the cycle a request is carried out
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic [IDX_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} list_cmd_t;

endpackage

[rtl/oal_if.sv]
// ----------------------------------------------------------------------------
// oal_req_if / oal_rsp_if
// Valid/ready channels of the ordered array list: requests in, results out.
// ----------------------------------------------------------------------------
interface oal_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [31:0] item_value;
	logic [3:0]         position;

	modport source (output valid, output func, output item_value, output position,
		input ready);
	modport sink (input valid, input func, input item_value, input position,
		output ready);
endinterface

interface oal_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] removed_value;
	logic [1:0]         status;
	logic [3:0]         entry_count;

	modport source (output valid, output removed_value, output status,
		output entry_count, input ready);
	modport sink (input valid, input removed_value, input status,
		input entry_count, output ready);
endinterface

[rtl/oal_ctrl.sv]
// ----------------------------------------------------------------------------
// oal_ctrl
// Request decoder: checks a request against the count, reports its status
// and builds the command for the row of cells and the next count.
// ----------------------------------------------------------------------------
module oal_ctrl #(
	parameter int CAPACITY = 8,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                             accept,
	input  logic [oal_pkg::FUNC_W-1:0]       func,
	input  logic signed [oal_pkg::DATA_W-1:0] item_value,
	input  logic [oal_pkg::POS_W-1:0]        position,
	input  logic [CNT_W-1:0]                 count,
	output oal_pkg::list_cmd_t               cmd,
	output oal_pkg::status_t                 status,
	output logic [CNT_W-1:0]                 count_next
);
	import oal_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	func_t            op;
	logic             is_ins;
	logic             is_rem;
	logic [IDX_W-1:0] pos;
	logic [IDX_W-1:0] cnt_ext;
	logic             ok;

	assign op = func_t'(func);
	assign cnt_ext = IDX_W'(count);

	// pick operation kind and target index
	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		pos = '0;
		unique case (op)
			FUNC_INS_HEAD: begin
				is_ins = 1'b1;
			end
			FUNC_INS_TAIL: begin
				is_ins = 1'b1;
				pos = cnt_ext;
			end
			FUNC_INS_POS: begin
				is_ins = 1'b1;
				pos = IDX_W'(position);
			end
			FUNC_REM_HEAD: begin
				is_rem = 1'b1;
			end
			FUNC_REM_TAIL: begin
				is_rem = 1'b1;
				pos = (count == '0) ? '0 : cnt_ext - IDX_W'(1);
			end
			FUNC_REM_POS: begin
				is_rem = 1'b1;
				pos = IDX_W'(position);
			end
			default: begin
			end
		endcase
	end

	// status check, full and empty take priority over range
	always_comb begin
		status = ST_OK;
		if (is_ins) begin
			if (count >= CAP_CNT)
				status = ST_FULL;
			else if (pos > cnt_ext)
				status = ST_RANGE;
		end else if (is_rem) begin
			if (count == '0)
				status = ST_EMPTY;
			else if (pos >= cnt_ext)
				status = ST_RANGE;
		end
	end

	assign ok = accept && (status == ST_OK);

	// command broadcast to the cells
	always_comb begin
		cmd.ins = ok && is_ins;
		cmd.rem = ok && is_rem;
		cmd.pos = pos;
		cmd.value = item_value;
	end

	// count after the request
	always_comb begin
		count_next = count;
		if (cmd.ins)
			count_next = count + CNT_W'(1);
		else if (cmd.rem)
			count_next = count - CNT_W'(1);
	end

endmodule

[rtl/oal_cell.sv]
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: holds its entry, loads an inserted value, or takes the
// entry of its lower neighbor on insert and of its upper neighbor on remove.
// ----------------------------------------------------------------------------
module oal_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  oal_pkg::list_cmd_t                cmd,
	input  logic signed [oal_pkg::DATA_W-1:0] left_value,
	input  logic signed [oal_pkg::DATA_W-1:0] right_value,
	output logic signed [oal_pkg::DATA_W-1:0] value_q
);
	import oal_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	// slot update
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == cmd.pos)
				value_q <= cmd.value;
			else if (MY_IDX > cmd.pos)
				value_q <= left_value;
		end else if (cmd.rem && (MY_IDX >= cmd.pos)) begin
			value_q <= right_value;
		end
	end

endmodule

[rtl/ordered_array_list.sv]
// ordered array list: one request carried out per cycle by a row of cells while results are taken
// result: registered, it appears in the cycle after its request is accepted
// throughput: one request per cycle unless a result stalls; all cells shift
//   in parallel, and the result register refills as its result is taken
// reset: the count and the result valid clear at once; entries are not reset
// ----------------------------------------------------------------------------
// ordered_array_list
// Ordered list of signed 32-bit values with inserts and removes at the head,
// the tail or a given position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
module ordered_array_list #(
	parameter int CAPACITY = 8
) (
	input logic       clk,
	input logic       arst_n,
	oal_req_if.sink   req,
	oal_rsp_if.source rsp
);
	import oal_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic                     accept;
	list_cmd_t                cmd;
	status_t                  status;
	logic signed [DATA_W-1:0] slot_value [CAPACITY];
	logic signed [DATA_W-1:0] taken;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] removed_value_q;
	status_t                  status_q;
	logic [COUNT_OUT_W-1:0]   entry_count_q;

	// a new request enters when the result register is free or being emptied
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	oal_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.accept     (accept),
		.func       (req.func),
		.item_value (req.item_value),
		.position   (req.position),
		.count      (count_q),
		.cmd        (cmd),
		.status     (status),
		.count_next (count_next)
	);

	// row of cells, each fed by its neighbors, with zero past either end
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_in;
		logic signed [DATA_W-1:0] right_in;
		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid
			assign left_in = slot_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = slot_value[i+1];
		end
		oal_cell #(
			.IDX(i)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.left_value  (left_in),
			.right_value (right_in),
			.value_q     (slot_value[i])
		);
	end

	// value leaving the list on a remove
	always_comb begin
		taken = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.rem && (cmd.pos == IDX_W'(i)))
				taken = taken | slot_value[i];
		end
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_next;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (accept)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q <= taken;
			status_q <= status;
			entry_count_q <= COUNT_OUT_W'(count_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.removed_value = removed_value_q;
	assign rsp.status = status_q;
	assign rsp.entry_count = entry_count_q;

endmodule

[rtl/oal_checker.sv]
// ----------------------------------------------------------------------------
// oal_checker
// Port-level checks of the ordered array list, attached by bind.
// ----------------------------------------------------------------------------
module oal_checker #(
	parameter int CAPACITY = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] removed_value,
	input logic [1:0]  status,
	input logic [3:0]  entry_count
);
	import oal_pkg::*;

	// a stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(removed_value)
			&& $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

	// every accepted request gives a result in the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request gave no result");

	// with no result pending the block takes requests
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("block stalled with empty result register");

	// a full report comes only from a list at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> (entry_count == 4'(CAPACITY))
			&& (removed_value == '0))
		else $error("full status with wrong count");

	// an empty report comes only from an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_EMPTY) |-> (entry_count == '0)
			&& (removed_value == '0))
		else $error("empty status with wrong count");

endmodule

bind ordered_array_list oal_checker #(
	.CAPACITY(CAPACITY)
) u_oal_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.removed_value (rsp.removed_value),
	.status        (rsp.status),
	.entry_count   (rsp.entry_count)
);
